/* design/lsep_pkg.sv */
// Shared types, constants and byte classification for the literal sum parser.
package lsep_pkg;

    localparam int WORD_BITS   = 16;
    localparam int VALUE_BITS  = 16;
    localparam int MAG_BITS    = 32;
    localparam int ACC_BITS    = MAG_BITS + 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    localparam logic [3:0] HEX_LETTER_OFFSET = 4'd9;

    localparam logic [MAG_BITS-1:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [MAG_BITS-1:0] MAG_CAP   = 32'h8000_0001;
    localparam logic [MAG_BITS-1:0] POS_MAX   = 32'h7FFF_FFFF;

    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [MAG_BITS-1:0]   mag_t;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_SIGN,
        MODE_CHAR0,
        MODE_CHAR1,
        MODE_ZERO,
        MODE_OCT,
        MODE_HEXPRE,
        MODE_HEX,
        MODE_DEC
    } mode_t;

    typedef struct packed {
        logic       sign;
        logic       minus;
        logic       quote;
        logic       zero;
        logic       nzdec;
        logic       dec;
        logic       oct;
        logic       hex;
        logic       x;
        logic [3:0] digit;
    } byte_class_t;

    typedef struct packed {
        logic [7:0]  code;
        logic        last;
        logic        space;
        byte_class_t cls;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef struct packed {
        logic take;
        logic take_last;
    } back_status_t;

    function automatic byte_class_t classify(input logic [7:0] c);
        byte_class_t r;
        r.sign  = (c == CH_PLUS) || (c == CH_MINUS);
        r.minus = (c == CH_MINUS);
        r.quote = (c == CH_QUOTE);
        r.zero  = (c == CH_ZERO);
        r.nzdec = (c >= CH_ONE) && (c <= CH_NINE);
        r.dec   = (c >= CH_ZERO) && (c <= CH_NINE);
        r.oct   = (c >= CH_ZERO) && (c <= CH_SEVEN);
        r.hex   = r.dec || ((c >= CH_A_LO) && (c <= CH_F_LO));
        r.x     = (c == CH_X_LO);
        r.digit = r.dec ? c[3:0] : c[3:0] + HEX_LETTER_OFFSET;
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    function automatic word_t to_word(input logic [MAG_BITS-1:0] v);
        return word_t'($signed(v));
    endfunction

endpackage

/* design/literal_sum_expression_parser.sv */
// Top level of the literal sum parser: front stage, queue and back stage.
// Takes one text byte per cycle and sustains one byte per cycle while full is
// low; whitespace bytes are dropped in the front stage unless marked last. Each
// byte goes through the front register, a four-word queue and the scanner
// update in the back stage, which sets the rate. The sum word appears on value
// the cycle after the back stage takes the byte marked last, and the front keeps
// taking the next expression while that word waits to be popped.
module literal_sum_expression_parser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [7:0]                char_code,
    input  logic                      last,
    output logic                      empty,
    input  logic                      pop,
    output logic [lsep_pkg::VALUE_BITS-1:0] value
);

    lsep_pkg::queue_status_t q_status;
    lsep_pkg::back_status_t  b_status;
    lsep_pkg::item_t         q_wr_item;
    lsep_pkg::item_t         q_rd_item;
    logic                    q_wr;
    logic                    q_rd;

    lsep_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_code (char_code),
        .last      (last),
        .q_status  (q_status),
        .q_wr      (q_wr),
        .q_item    (q_wr_item)
    );

    lsep_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_item (q_wr_item),
        .rd_en   (q_rd),
        .rd_item (q_rd_item),
        .status  (q_status)
    );

    lsep_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head     (q_rd_item),
        .q_rd     (q_rd),
        .empty    (empty),
        .pop      (pop),
        .value    (value),
        .status   (b_status)
    );

`ifndef SYNTHESIS
    a_take_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        b_status.take |-> !q_status.empty)
        else $error("back stage took a word from an empty queue");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (b_status.take_last && !empty) |-> pop)
        else $error("result slot overwritten before pop");

    a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
        b_status.take_last |=> !empty)
        else $error("no result after the last byte");

    a_full_only_on_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_status.full)
        else $error("front stalled with room in the queue");
`endif

endmodule

/* design/lsep_front.sv */
// Front stage: accept bytes, drop whitespace not marked last, classify and hand words to the queue.
module lsep_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             char_code,
    input  logic                   last,
    input  lsep_pkg::queue_status_t q_status,
    output logic                   q_wr,
    output lsep_pkg::item_t        q_item
);

    logic            stage_valid_reg;
    logic            stage_valid_next;
    lsep_pkg::item_t stage_item_reg;
    lsep_pkg::item_t in_item;
    logic            accept;
    logic            keep;

    assign full   = stage_valid_reg && q_status.full;
    assign accept = push && !full;
    assign q_wr   = stage_valid_reg && !q_status.full;
    assign q_item = stage_item_reg;

    always_comb
    begin
        in_item.code  = char_code;
        in_item.last  = last;
        in_item.space = lsep_pkg::is_space(char_code);
        in_item.cls   = lsep_pkg::classify(char_code);
        keep          = !in_item.space || last;
    end

    always_comb
    begin
        if (accept && keep)
        begin
            stage_valid_next = 1'b1;
        end
        else if (q_wr)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            stage_item_reg <= in_item;
        end
    end

endmodule

/* design/lsep_fifo.sv */
// Short queue of classified words between the front and back stages.
module lsep_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  lsep_pkg::item_t         wr_item,
    input  logic                    rd_en,
    output lsep_pkg::item_t         rd_item,
    output lsep_pkg::queue_status_t status
);

    lsep_pkg::item_t                  mem_reg [lsep_pkg::QUEUE_DEPTH];
    logic [lsep_pkg::QPTR_BITS-1:0]   wr_ptr_reg;
    logic [lsep_pkg::QPTR_BITS-1:0]   rd_ptr_reg;
    logic [lsep_pkg::QCNT_BITS-1:0]   count_reg;
    logic [lsep_pkg::QCNT_BITS-1:0]   count_next;
    logic                             do_wr;
    logic                             do_rd;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == lsep_pkg::QCNT_BITS'(lsep_pkg::QUEUE_DEPTH));
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_item      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

/* design/lsep_back.sv */
// Back stage: literal scanner, saturating accumulation and the result slot.
module lsep_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lsep_pkg::queue_status_t q_status,
    input  lsep_pkg::item_t         head,
    output logic                    q_rd,
    output logic                    empty,
    input  logic                    pop,
    output lsep_pkg::value_t        value,
    output lsep_pkg::back_status_t  status
);

    typedef struct packed {
        lsep_pkg::mode_t mode;
        logic            neg;
        lsep_pkg::mag_t  mag;
    } scan_t;

    lsep_pkg::mode_t mode_reg;
    lsep_pkg::mode_t mode_next;
    logic            neg_reg;
    logic            neg_next;
    lsep_pkg::mag_t  mag_reg;
    lsep_pkg::mag_t  mag_next;
    lsep_pkg::item_t held_reg;
    lsep_pkg::item_t held_next;
    lsep_pkg::word_t sum_reg;
    lsep_pkg::word_t sum_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    lsep_pkg::word_t out_base_reg;
    lsep_pkg::word_t out_base_next;
    lsep_pkg::word_t out_add_reg;
    lsep_pkg::word_t out_add_next;
    logic            take;
    scan_t           s;
    scan_t           f;
    lsep_pkg::word_t add1;
    lsep_pkg::word_t add2;
    lsep_pkg::mag_t  char_val;

    function automatic scan_t body_start(input scan_t si, input lsep_pkg::byte_class_t c);
        scan_t r;
        r      = si;
        r.mag  = '0;
        r.mode = lsep_pkg::MODE_IDLE;
        if (c.quote)
        begin
            r.mode = lsep_pkg::MODE_CHAR0;
        end
        else if (c.zero)
        begin
            r.mode = lsep_pkg::MODE_ZERO;
        end
        else if (c.nzdec)
        begin
            r.mode = lsep_pkg::MODE_DEC;
            r.mag  = lsep_pkg::MAG_BITS'(c.digit);
        end
        return r;
    endfunction

    function automatic scan_t idle_start(input lsep_pkg::byte_class_t c);
        scan_t r;
        r.mode = lsep_pkg::MODE_IDLE;
        r.neg  = 1'b0;
        r.mag  = '0;
        if (c.sign)
        begin
            r.mode = lsep_pkg::MODE_SIGN;
            r.neg  = c.minus;
        end
        else
        begin
            r = body_start(r, c);
        end
        return r;
    endfunction

    function automatic lsep_pkg::mag_t accumulate(input lsep_pkg::mag_t m,
                                                 input logic [3:0] d,
                                                 input lsep_pkg::mode_t base);
        logic [lsep_pkg::ACC_BITS-1:0] t;
        case (base)
            lsep_pkg::MODE_OCT: t = {1'b0, m, 3'b000};
            lsep_pkg::MODE_HEX: t = {m, 4'b0000};
            lsep_pkg::MODE_DEC: t = {1'b0, m, 3'b000} + {3'b000, m, 1'b0};
            default:            t = '0;
        endcase
        t = t + lsep_pkg::ACC_BITS'(d);
        if (t > lsep_pkg::ACC_BITS'(lsep_pkg::MAG_LIMIT))
        begin
            return lsep_pkg::MAG_CAP;
        end
        return t[lsep_pkg::MAG_BITS-1:0];
    endfunction

    function automatic lsep_pkg::word_t finish(input scan_t si);
        lsep_pkg::mag_t v;
        if (si.neg)
        begin
            v = (si.mag >= lsep_pkg::MAG_LIMIT) ? lsep_pkg::MAG_LIMIT : ('0 - si.mag);
        end
        else
        begin
            v = (si.mag > lsep_pkg::POS_MAX) ? lsep_pkg::POS_MAX : si.mag;
        end
        return lsep_pkg::to_word(v);
    endfunction

    function automatic logic is_numeric(input lsep_pkg::mode_t m);
        return (m == lsep_pkg::MODE_ZERO) || (m == lsep_pkg::MODE_OCT) ||
               (m == lsep_pkg::MODE_HEXPRE) || (m == lsep_pkg::MODE_HEX) ||
               (m == lsep_pkg::MODE_DEC);
    endfunction

    assign take  = !q_status.empty && (!head.last || !out_valid_reg || pop);
    assign q_rd  = take;
    assign empty = !out_valid_reg;
    assign value = lsep_pkg::value_t'(out_base_reg + out_add_reg);

    assign status.take      = take;
    assign status.take_last = take && head.last;

    always_comb
    begin
        s.mode    = mode_reg;
        s.neg     = neg_reg;
        s.mag     = mag_reg;
        held_next = held_reg;
        add1      = '0;
        add2      = '0;
        char_val  = '0;

        if (take && !head.space)
        begin
            // rescan the held byte after a broken char literal
            if (s.mode == lsep_pkg::MODE_CHAR1 && !head.cls.quote)
            begin
                s = idle_start(held_reg.cls);
            end
            case (s.mode)
                lsep_pkg::MODE_IDLE:
                begin
                    s = idle_start(head.cls);
                end
                lsep_pkg::MODE_SIGN:
                begin
                    if (head.cls.quote || head.cls.zero || head.cls.nzdec)
                    begin
                        s = body_start(s, head.cls);
                    end
                    else
                    begin
                        s = idle_start(head.cls);
                    end
                end
                lsep_pkg::MODE_CHAR0:
                begin
                    held_next = head;
                    s.mode    = lsep_pkg::MODE_CHAR1;
                end
                lsep_pkg::MODE_CHAR1:
                begin
                    char_val = lsep_pkg::MAG_BITS'($signed(held_reg.code));
                    if (s.neg)
                    begin
                        char_val = '0 - char_val;
                    end
                    add1   = lsep_pkg::to_word(char_val);
                    s.mode = lsep_pkg::MODE_IDLE;
                    s.neg  = 1'b0;
                    s.mag  = '0;
                end
                lsep_pkg::MODE_ZERO:
                begin
                    if (head.cls.x)
                    begin
                        s.mode = lsep_pkg::MODE_HEXPRE;
                    end
                    else if (head.cls.oct)
                    begin
                        s.mode = lsep_pkg::MODE_OCT;
                        s.mag  = accumulate(s.mag, head.cls.digit, lsep_pkg::MODE_OCT);
                    end
                    else
                    begin
                        add1 = finish(s);
                        s    = idle_start(head.cls);
                    end
                end
                lsep_pkg::MODE_OCT:
                begin
                    if (head.cls.oct)
                    begin
                        s.mag = accumulate(s.mag, head.cls.digit, lsep_pkg::MODE_OCT);
                    end
                    else
                    begin
                        add1 = finish(s);
                        s    = idle_start(head.cls);
                    end
                end
                lsep_pkg::MODE_HEXPRE, lsep_pkg::MODE_HEX:
                begin
                    if (head.cls.hex)
                    begin
                        s.mode = lsep_pkg::MODE_HEX;
                        s.mag  = accumulate(s.mag, head.cls.digit, lsep_pkg::MODE_HEX);
                    end
                    else
                    begin
                        add1 = finish(s);
                        s    = idle_start(head.cls);
                    end
                end
                lsep_pkg::MODE_DEC:
                begin
                    if (head.cls.dec)
                    begin
                        s.mag = accumulate(s.mag, head.cls.digit, lsep_pkg::MODE_DEC);
                    end
                    else
                    begin
                        add1 = finish(s);
                        s    = idle_start(head.cls);
                    end
                end
                default:
                begin
                    s.mode = lsep_pkg::MODE_IDLE;
                    s.neg  = 1'b0;
                    s.mag  = '0;
                end
            endcase
        end

        // end of text: close any open literal
        f = s;
        if (f.mode == lsep_pkg::MODE_CHAR1)
        begin
            f = idle_start(held_next.cls);
        end
        if (is_numeric(f.mode))
        begin
            add2 = finish(f);
        end

        mode_next      = s.mode;
        neg_next       = s.neg;
        mag_next       = s.mag;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !pop;
        out_base_next  = out_base_reg;
        out_add_next   = out_add_reg;

        if (take)
        begin
            if (head.last)
            begin
                out_valid_next = 1'b1;
                out_base_next  = sum_reg + add1;
                out_add_next   = add2;
                sum_next       = '0;
                mode_next      = lsep_pkg::MODE_IDLE;
                neg_next       = 1'b0;
                mag_next       = '0;
            end
            else
            begin
                sum_next = sum_reg + add1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= lsep_pkg::MODE_IDLE;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            neg_reg       <= neg_next;
            mag_reg       <= mag_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg     <= held_next;
        out_base_reg <= out_base_next;
        out_add_reg  <= out_add_next;
    end

endmodule
